// ----- rtl/core/ffga_pkg.sv -----
// ----------------------------------------------------------------------------
// ffga_pkg
// Shared types and constants for the first-fit gap allocator.
// ----------------------------------------------------------------------------
package ffga_pkg;

   localparam int SLOTS  = 128;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(SLOTS + 1);
   localparam int LEN_W  = 17;
   localparam int TKT_W  = 16;
   localparam int GAP_W  = 8;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_LOT_LENGTH = 2'd0;
   localparam logic [1:0] REG_GAP_BEFORE = 2'd1;
   localparam logic [1:0] REG_GAP_AFTER  = 2'd2;

   localparam logic [LEN_W-1:0] LOT_LENGTH_RESET = LEN_W'(1000);
   localparam logic [GAP_W-1:0] GAP_BEFORE_RESET = GAP_W'(1);
   localparam logic [GAP_W-1:0] GAP_AFTER_RESET  = GAP_W'(1);

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_REL_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] seg_start;
      logic [LEN_W-1:0] seg_end;
      logic [TKT_W-1:0] seg_ticket;
   } seg_entry_type;

   typedef struct packed {
      logic load;        // latch request, advance ticket counter, rewind scan
      logic scan_step;   // move scan to next entry
      logic shift_init;  // set shift pointer for the chosen direction
      logic shift_step;  // one move of the table shift
      logic shift_up;    // direction: 1 open a hole, 0 close a hole
      logic write_new;   // write new segment at scan index
      logic count_dec;
      logic rsp_ok;
      logic rsp_fail;
   } dp_cmd_type;

   typedef struct packed {
      logic is_release;
      logic arg_zero;
      logic full;
      logic scan_end;
      logic fit;
      logic match;
      logic up_done;
      logic down_done;
   } dp_status_type;

endpackage

// ----- rtl/core/ffga_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffga_ctrl
// Sequencer for scan, table shift and response of the gap allocator.
// ----------------------------------------------------------------------------
module ffga_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffga_pkg::dp_status_type status,
   output ffga_pkg::dp_cmd_type   cmd
);
   import ffga_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.is_release) begin
                  if (!status.arg_zero) begin
                     state_in = ST_REL_SCAN;
                  end
               end else if (status.full) begin
                  cmd.rsp_fail = 1'b1;
               end else begin
                  state_in = ST_ALLOC_SCAN;
               end
            end
         end
         ST_ALLOC_SCAN: begin
            if (status.fit) begin
               cmd.shift_init = 1'b1;
               cmd.shift_up   = 1'b1;
               state_in       = ST_SHIFT_UP;
            end else if (status.scan_end) begin
               cmd.rsp_fail = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_REL_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_IDLE;
            end else if (status.match) begin
               cmd.shift_init = 1'b1;
               state_in       = ST_SHIFT_DOWN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SHIFT_UP: begin
            cmd.shift_up = 1'b1;
            if (status.up_done) begin
               cmd.write_new = 1'b1;
               cmd.rsp_ok    = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_SHIFT_DOWN: begin
            if (status.down_done) begin
               cmd.count_dec = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/ffga_dp.sv -----
// ----------------------------------------------------------------------------
// ffga_dp
// Segment table memory, scan and fit arithmetic, shift pointers, result regs.
// ----------------------------------------------------------------------------
module ffga_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_cmd,
   input  logic [ffga_pkg::LEN_W-1:0]    req_length_or_ticket,
   input  logic [ffga_pkg::LEN_W-1:0]    lot_length,
   input  logic [ffga_pkg::GAP_W-1:0]    gap_before,
   input  logic [ffga_pkg::GAP_W-1:0]    gap_after,
   input  ffga_pkg::dp_cmd_type          cmd,
   output ffga_pkg::dp_status_type       status,
   output logic                          rsp_valid,
   output logic [ffga_pkg::LEN_W-1:0]    rsp_start_position,
   output logic                          rsp_no_room
);
   import ffga_pkg::*;

   localparam int SUM_W = LEN_W + 2;

   seg_entry_type mem [SLOTS];
   seg_entry_type rd_data_ff;
   seg_entry_type wr_data;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  rd_full;
   logic [ADDR_W-1:0] mv_addr_ff, mv_addr_in;
   logic              pend_ff, pend_in;
   logic [LEN_W-1:0]  arg_ff, arg_in;
   logic [LEN_W-1:0]  prev_end_ff, prev_end_in;
   logic [TKT_W-1:0]  ticket_ff, ticket_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]  rsp_start_ff, rsp_start_in;
   logic              rsp_no_room_ff, rsp_no_room_in;

   logic [LEN_W:0]    cand;
   logic [SUM_W-1:0]  seg_top;
   logic [SUM_W-1:0]  limit_sum;
   logic              up_more, down_more;

   // candidate start: left end of the line, or gap_before past previous end
   always_comb begin
      if (idx_ff == '0) begin
         cand = '0;
      end else begin
         cand = {1'b0, prev_end_ff} + (LEN_W + 1)'(gap_before);
      end
      seg_top   = {1'b0, cand} + SUM_W'(arg_ff);
      limit_sum = seg_top + SUM_W'(gap_after);
   end

   assign up_more   = (ptr_ff != idx_ff);
   assign down_more = ((ptr_ff + IDX_W'(1)) < count_ff);

   always_comb begin
      status.is_release = (req_cmd == CMD_RELEASE);
      status.arg_zero   = (req_length_or_ticket == '0);
      status.full       = (count_ff == IDX_W'(SLOTS));
      status.scan_end   = (idx_ff == count_ff);
      status.fit        = status.scan_end ? (seg_top <= SUM_W'(lot_length))
                                          : (limit_sum <= SUM_W'(rd_data_ff.seg_start));
      status.match      = !status.scan_end && ({1'b0, rd_data_ff.seg_ticket} == arg_ff);
      status.up_done    = !up_more && !pend_ff;
      status.down_done  = !down_more && !pend_ff;
   end

   always_comb begin
      idx_in         = idx_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      mv_addr_in     = mv_addr_ff;
      pend_in        = pend_ff;
      arg_in         = arg_ff;
      prev_end_in    = prev_end_ff;
      ticket_in      = ticket_ff;
      rsp_valid_in   = 1'b0;
      rsp_start_in   = rsp_start_ff;
      rsp_no_room_in = rsp_no_room_ff;
      rd_full        = idx_in;
      wr_en          = 1'b0;
      wr_addr        = mv_addr_ff;
      wr_data        = rd_data_ff;

      if (cmd.load) begin
         arg_in = req_length_or_ticket;
         idx_in = '0;
         if (ticket_ff != '1) begin
            ticket_in = ticket_ff + TKT_W'(1);
         end
      end
      if (cmd.scan_step) begin
         idx_in      = idx_ff + IDX_W'(1);
         prev_end_in = rd_data_ff.seg_end;
      end
      rd_full = idx_in;

      if (cmd.shift_init) begin
         pend_in = 1'b0;
         ptr_in  = cmd.shift_up ? count_ff : idx_ff;
      end

      // pipelined move: read one entry, write it to its neighbor next cycle
      if (cmd.shift_step) begin
         if (pend_ff) begin
            wr_en = 1'b1;
         end
         pend_in = 1'b0;
         if (cmd.shift_up && up_more) begin
            rd_full    = ptr_ff - IDX_W'(1);
            mv_addr_in = ptr_ff[ADDR_W-1:0];
            ptr_in     = ptr_ff - IDX_W'(1);
            pend_in    = 1'b1;
         end else if (!cmd.shift_up && down_more) begin
            rd_full    = ptr_ff + IDX_W'(1);
            mv_addr_in = ptr_ff[ADDR_W-1:0];
            ptr_in     = ptr_ff + IDX_W'(1);
            pend_in    = 1'b1;
         end
      end

      if (cmd.write_new) begin
         wr_en              = 1'b1;
         wr_addr            = idx_ff[ADDR_W-1:0];
         wr_data.seg_start  = cand[LEN_W-1:0];
         wr_data.seg_end    = seg_top[LEN_W-1:0];
         wr_data.seg_ticket = ticket_ff;
         count_in           = count_ff + IDX_W'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - IDX_W'(1);
      end

      if (cmd.rsp_ok) begin
         rsp_valid_in   = 1'b1;
         rsp_start_in   = cand[LEN_W-1:0];
         rsp_no_room_in = 1'b0;
      end
      if (cmd.rsp_fail) begin
         rsp_valid_in   = 1'b1;
         rsp_start_in   = '0;
         rsp_no_room_in = 1'b1;
      end
   end

   assign rd_addr = rd_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ticket_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ticket_ff    <= ticket_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      ptr_ff         <= ptr_in;
      mv_addr_ff     <= mv_addr_in;
      arg_ff         <= arg_in;
      prev_end_ff    <= prev_end_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_no_room_ff <= rsp_no_room_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_start_position = rsp_start_ff;
   assign rsp_no_room        = rsp_no_room_ff;

endmodule

// ----- rtl/core/first_fit_gap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_gap_allocator
// First-fit segment allocator over a line of configurable length.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An allocate with the
// table full, or a release of ticket 0, is settled from the idle state with
// no scan. Otherwise the block scans the sorted segment table one entry per
// cycle and then, when it places or frees a segment, shifts the entries above
// the insert or delete point one per cycle, with a final step that writes the
// last moved entry. The pace is set by the segment table memory, which does
// one read and one write per cycle. An allocate answers with a one-cycle
// rsp_valid strobe as it finishes; a release gives no transfer. Results
// cannot be held off, so the receiver must take every strobe. Segment table
// entries start unwritten; only entries below the fill count are ever used,
// so no clearing pass runs.
// ----------------------------------------------------------------------------
module first_fit_gap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [ffga_pkg::LEN_W-1:0]        req_length_or_ticket,
   output logic                              rsp_valid,
   output logic [ffga_pkg::LEN_W-1:0]        rsp_start_position,
   output logic                              rsp_no_room,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffga_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ffga_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ffga_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import ffga_pkg::*;

   logic [LEN_W-1:0] lot_length_ff, lot_length_in;
   logic [GAP_W-1:0] gap_before_ff, gap_before_in;
   logic [GAP_W-1:0] gap_after_ff, gap_after_in;
   logic             csr_wr;
   dp_cmd_type       cmd;
   dp_status_type    status;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      lot_length_in = lot_length_ff;
      gap_before_in = gap_before_ff;
      gap_after_in  = gap_after_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            REG_LOT_LENGTH: lot_length_in = pwdata[LEN_W-1:0];
            REG_GAP_BEFORE: gap_before_in = pwdata[GAP_W-1:0];
            REG_GAP_AFTER:  gap_after_in  = pwdata[GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_LOT_LENGTH: prdata = CSR_DATA_W'(lot_length_ff);
         REG_GAP_BEFORE: prdata = CSR_DATA_W'(gap_before_ff);
         REG_GAP_AFTER:  prdata = CSR_DATA_W'(gap_after_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lot_length_ff <= LOT_LENGTH_RESET;
         gap_before_ff <= GAP_BEFORE_RESET;
         gap_after_ff  <= GAP_AFTER_RESET;
      end else begin
         lot_length_ff <= lot_length_in;
         gap_before_ff <= gap_before_in;
         gap_after_ff  <= gap_after_in;
      end
   end

   ffga_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ffga_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_cmd              (req_cmd),
      .req_length_or_ticket (req_length_or_ticket),
      .lot_length           (lot_length_ff),
      .gap_before           (gap_before_ff),
      .gap_after            (gap_after_ff),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_start_position   (rsp_start_position),
      .rsp_no_room          (rsp_no_room)
   );

endmodule

// ----- test/tb_first_fit_gap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_gap_allocator
// Self-checking bench for the first-fit gap allocator. A queue-fed driver
// offers allocate and release commands with random idle bursts, a clocked
// monitor checks every result strobe against a segment-table predictor, and
// the APB registers are rewritten between phases once the block is drained.
// ----------------------------------------------------------------------------
module tb_first_fit_gap_allocator;
   import ffga_pkg::*;

   localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
   localparam int QUIET_LIMIT  = 4000;

   typedef struct packed {
      logic             cmd;
      logic [LEN_W-1:0] arg;
   } request_type;

   typedef struct packed {
      logic [LEN_W-1:0] start_position;
      logic             no_room;
   } placement_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_cmd = CMD_ALLOCATE;
   logic [LEN_W-1:0]      req_length_or_ticket = '0;
   logic                  rsp_valid;
   logic [LEN_W-1:0]      rsp_start_position;
   logic                  rsp_no_room;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   first_fit_gap_allocator dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_length_or_ticket (req_length_or_ticket),
      .rsp_valid            (rsp_valid),
      .rsp_start_position   (rsp_start_position),
      .rsp_no_room          (rsp_no_room),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor copy of registers and segment table
   logic [LEN_W-1:0] cfg_lot_length = LOT_LENGTH_RESET;
   logic [GAP_W-1:0] cfg_gap_before = GAP_BEFORE_RESET;
   logic [GAP_W-1:0] cfg_gap_after  = GAP_AFTER_RESET;
   logic [LEN_W-1:0] occ_start  [SLOTS];
   logic [LEN_W-1:0] occ_end    [SLOTS];
   logic [TKT_W-1:0] occ_ticket [SLOTS];
   int               occ_fill   = 0;
   logic [TKT_W-1:0] ticket_ctr = '0;

   request_type      pending_requests [$];
   placement_type    placements_due   [$];
   logic [TKT_W-1:0] live_tickets     [$];
   logic [TKT_W-1:0] issued_ticket = '0;
   int               idle_pct      = 0;
   int               idle_left     = 0;
   int               mismatches    = 0;
   int               quiet_cycles  = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Computes the outcome of one accepted command and updates the table.
   task automatic apply_request(input logic cmd, input logic [LEN_W-1:0] arg);
      placement_type res;
      longint        cand;
      bit            fits;
      bit            done;
      int            i;
      int            j;
      done = 1'b0;
      if (ticket_ctr != {TKT_W{1'b1}})
         ticket_ctr++;
      if (cmd == CMD_ALLOCATE) begin
         res.start_position = '0;
         res.no_room = 1'b1;
         if (occ_fill < SLOTS) begin
            for (i = 0; i <= occ_fill && !done; i++) begin
               // no gap applies at the left end of the line
               cand = (i == 0) ? 64'd0
                               : longint'(occ_end[i-1]) + longint'(cfg_gap_before);
               if (i < occ_fill)
                  fits = cand + longint'(arg) + longint'(cfg_gap_after)
                         <= longint'(occ_start[i]);
               else
                  fits = cand + longint'(arg) <= longint'(cfg_lot_length);
               if (fits) begin
                  for (j = occ_fill; j > i; j--) begin
                     occ_start[j]  = occ_start[j-1];
                     occ_end[j]    = occ_end[j-1];
                     occ_ticket[j] = occ_ticket[j-1];
                  end
                  occ_start[i]  = cand[LEN_W-1:0];
                  occ_end[i]    = LEN_W'(cand + longint'(arg));
                  occ_ticket[i] = ticket_ctr;
                  occ_fill++;
                  res.start_position = cand[LEN_W-1:0];
                  res.no_room = 1'b0;
                  done = 1'b1;
               end
            end
         end
         placements_due.push_back(res);
      end else if (arg != '0) begin
         for (i = 0; i < occ_fill && !done; i++) begin
            if ({1'b0, occ_ticket[i]} == arg) begin
               for (j = i; j + 1 < occ_fill; j++) begin
                  occ_start[j]  = occ_start[j+1];
                  occ_end[j]    = occ_end[j+1];
                  occ_ticket[j] = occ_ticket[j+1];
               end
               occ_fill--;
               done = 1'b1;
            end
         end
      end
   endtask

   // driver: one transfer per accept edge, idle bursts between items
   always @(posedge clock) begin
      request_type nxt;
      if (!reset) begin
         if (start && !busy) begin
            apply_request(req_cmd, req_length_or_ticket);
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
               idle_left = $urandom_range(15, 1);
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               nxt = pending_requests.pop_front();
               start <= 1'b1;
               req_cmd <= nxt.cmd;
               req_length_or_ticket <= nxt.arg;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: results cannot be stalled, every strobe is a transfer
   always @(posedge clock) begin
      placement_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (placements_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result start=%0d no_room=%0b",
                                      rsp_start_position, rsp_no_room));
         end else begin
            due = placements_due.pop_front();
            if (rsp_start_position !== due.start_position)
               report_mismatch($sformatf("start_position %0d, expected %0d",
                                         rsp_start_position, due.start_position));
            if (rsp_no_room !== due.no_room)
               report_mismatch($sformatf("no_room %0b, expected %0b",
                                         rsp_no_room, due.no_room));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_first_fit_gap_allocator failed");
            $finish;
         end
      end
   end

   // APB write followed by a read-back of the same register
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] stored;
      case (idx)
         REG_LOT_LENGTH: stored = {15'd0, value[LEN_W-1:0]};
         REG_GAP_BEFORE: stored = {24'd0, value[GAP_W-1:0]};
         default:        stored = {24'd0, value[GAP_W-1:0]};
      endcase
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_LOT_LENGTH: cfg_lot_length = value[LEN_W-1:0];
         REG_GAP_BEFORE: cfg_gap_before = value[GAP_W-1:0];
         REG_GAP_AFTER:  cfg_gap_after  = value[GAP_W-1:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored)
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   idx, prdata, stored));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_registers(input logic [31:0] lot, input logic [31:0] before_gap,
                                input logic [31:0] after_gap);
      write_register(REG_LOT_LENGTH, lot);
      write_register(REG_GAP_BEFORE, before_gap);
      write_register(REG_GAP_AFTER, after_gap);
   endtask

   // tracks the ticket each queued item will get, so releases can hit
   task automatic queue_request(input logic cmd, input logic [LEN_W-1:0] arg);
      request_type r;
      r.cmd = cmd;
      r.arg = arg;
      pending_requests.push_back(r);
      if (issued_ticket != {TKT_W{1'b1}})
         issued_ticket++;
      if (cmd == CMD_ALLOCATE)
         live_tickets.push_back(issued_ticket);
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return LEN_W'($urandom_range(int'(cfg_lot_length) / 16 + 1, 0));
      else if (r < 85)
         return LEN_W'($urandom_range(255, 0));
      else if (r < 95)
         return LEN_W'($urandom_range(int'(cfg_lot_length), 0));
      return LEN_W'($urandom_range((1 << LEN_W) - 1, 0));
   endfunction

   task automatic queue_random(input int count, input int alloc_pct);
      int               r;
      int               k;
      int               pick;
      logic [TKT_W-1:0] tkt;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < alloc_pct || live_tickets.size() == 0) begin
            queue_request(CMD_ALLOCATE, pick_length());
         end else if (r < 94) begin
            pick = $urandom_range(live_tickets.size() - 1, 0);
            tkt = live_tickets[pick];
            live_tickets.delete(pick);
            queue_request(CMD_RELEASE, {1'b0, tkt});
         end else begin
            // noise: ticket zero, any 17-bit value, or any ticket issued so far
            case ($urandom_range(2))
               0:       queue_request(CMD_RELEASE, '0);
               1:       queue_request(CMD_RELEASE, LEN_W'($urandom_range((1 << LEN_W) - 1)));
               default: queue_request(CMD_RELEASE,
                                      LEN_W'($urandom_range(int'(issued_ticket), 0)));
            endcase
         end
      end
   endtask

   // waits for the sender to go quiet and every result to arrive, then lets
   // a trailing release finish
   task automatic settle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || start || placements_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, zero length, over-long, exact fit at the
      // right end, ticket zero, unmatched tickets, hole reuse
      idle_pct = 20;
      queue_request(CMD_ALLOCATE, 17'd0);
      queue_request(CMD_ALLOCATE, 17'd131071);
      queue_request(CMD_ALLOCATE, 17'd1000);
      queue_request(CMD_ALLOCATE, 17'd999);
      queue_request(CMD_RELEASE, 17'd0);
      queue_request(CMD_RELEASE, 17'd131071);
      queue_request(CMD_RELEASE, 17'd65536);
      queue_request(CMD_RELEASE, 17'd4);
      queue_request(CMD_RELEASE, 17'd4);
      queue_request(CMD_ALLOCATE, 17'd10);
      queue_request(CMD_ALLOCATE, 17'd20);
      queue_request(CMD_RELEASE, 17'd10);
      queue_request(CMD_ALLOCATE, 17'd9);
      queue_request(CMD_ALLOCATE, 17'd10);
      queue_request(CMD_RELEASE, 17'd1);
      queue_request(CMD_ALLOCATE, 17'd0);
      settle();

      // fill the table past full, then churn holes
      set_registers(32'd131071, 32'd0, 32'd0);
      idle_pct = 30;
      for (p = 0; p < 132; p++)
         queue_request(CMD_ALLOCATE, LEN_W'($urandom_range(40, 0)));
      queue_random(60, 50);
      settle();

      // shortest line, widest gaps, no idling
      set_registers(32'd1, 32'd255, 32'd255);
      idle_pct = 0;
      queue_random(60, 50);
      settle();

      set_registers(32'd1000, 32'd0, 32'd255);
      idle_pct = 50;
      queue_random(120, 55);
      settle();

      for (p = 0; p < 3; p++) begin
         set_registers($urandom_range(20000, 200), $urandom_range(255, 0),
                       $urandom_range(255, 0));
         idle_pct = $urandom_range(60, 0);
         queue_random(120, 55);
         settle();
      end

      // closing part: no idling from here on
      set_registers(32'd131071, 32'd255, 32'd0);
      idle_pct = 0;
      queue_random(120, 55);
      settle();

      // a few more segments, then releases of high tickets that match nothing
      for (p = 0; p < 4; p++)
         queue_request(CMD_ALLOCATE, LEN_W'($urandom_range(30, 0)));
      queue_request(CMD_RELEASE, 17'd65535);
      queue_request(CMD_RELEASE, 17'd65535);
      queue_request(CMD_RELEASE, 17'd65534);
      queue_request(CMD_ALLOCATE, 17'd3);
      queue_request(CMD_ALLOCATE, 17'd0);
      settle();

      if (mismatches == 0)
         $display("tb_first_fit_gap_allocator passed");
      else
         $display("tb_first_fit_gap_allocator failed");
      $finish;
   end

endmodule

// ----- first_fit_gap_allocator.f -----
rtl/core/ffga_pkg.sv
rtl/core/ffga_ctrl.sv
rtl/core/ffga_dp.sv
rtl/core/first_fit_gap_allocator.sv
test/tb_first_fit_gap_allocator.sv
